// ===== rtl/core/tcwp_pkg.sv =====
// shared constants, types and helper functions of the world-position unit
`timescale 1ns / 1ps
package tcwp_pkg;

    localparam int NODES    = 1024;
    localparam int IDX_W    = $clog2(NODES);
    localparam int HOP_MAX  = 256;
    localparam int LIMIT_W  = 9;
    localparam int RND_W    = 48;
    localparam int ACC_W    = 50;

    localparam logic [2:0] OP_POS   = 3'd0;
    localparam logic [2:0] OP_ROT   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_PAR   = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    typedef logic signed [RND_W-1:0] rnd_t;
    typedef rnd_t qprod_t [9];

    // clamp a wide signed value into signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff}))
            r = 32'sh7fff_ffff;
        else if (x < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000}))
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // rotation coefficient k(i,j), idx = 3*i + j; products xx yy zz xy xz yz xw yw zw
    function automatic logic signed [31:0] kcoef(input logic [3:0] idx, input qprod_t q);
        logic signed [ACC_W-1:0] p0;
        logic signed [ACC_W-1:0] p1;
        logic signed [ACC_W-1:0] s;
        p0 = '0;
        p1 = '0;
        s  = '0;
        case (idx)
            4'd0: begin p0 = ACC_W'(q[1]); p1 = ACC_W'(q[2]); s = -(p0 + p1); end
            4'd1: begin p0 = ACC_W'(q[3]); p1 = ACC_W'(q[8]); s = p0 - p1; end
            4'd2: begin p0 = ACC_W'(q[4]); p1 = ACC_W'(q[7]); s = p0 + p1; end
            4'd3: begin p0 = ACC_W'(q[3]); p1 = ACC_W'(q[8]); s = p0 + p1; end
            4'd4: begin p0 = ACC_W'(q[0]); p1 = ACC_W'(q[2]); s = -(p0 + p1); end
            4'd5: begin p0 = ACC_W'(q[5]); p1 = ACC_W'(q[6]); s = p0 - p1; end
            4'd6: begin p0 = ACC_W'(q[4]); p1 = ACC_W'(q[7]); s = p0 - p1; end
            4'd7: begin p0 = ACC_W'(q[5]); p1 = ACC_W'(q[6]); s = p0 + p1; end
            4'd8: begin p0 = ACC_W'(q[0]); p1 = ACC_W'(q[1]); s = -(p0 + p1); end
            default: s = '0;
        endcase
        return sat32(s <<< 1);
    endfunction

endpackage

// ===== rtl/core/transform_chain_world_position.sv =====
// top level: node table, hop sequencer and result register of the world-position unit
//
//  port group   dir  role
//  s_*          in   node writes (op 0..3) and queries (op 4)
//  m_*          out  world position of a query, limit flag
//  p*           in   apb register port, hop_limit at address 0
//
// a write is stored on acceptance; a query walks the parent chain, and each hop
// runs 21 products through the one shared multiplier, drains its pipeline, updates
// the position and checks the next link; the result is held until it is taken; the
// multiplier and the single read port keep the hops strictly one after another
// reset clears the sequencer and sets hop_limit to 256; the node table is not cleared
// s_tready is low from query acceptance until its result request is taken
`timescale 1ns / 1ps
module transform_chain_world_position (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [143:0]  s_tdata,   // entry[9:0], a, b, c, d (32 each), zero fill
    input  logic [2:0]    s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // world_x, world_y, world_z
    output logic [0:0]    m_tuser,   // limit_hit
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [0:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tcwp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_START, S_CHECK, S_HOP, S_OUT} state_t;

    localparam logic [4:0] STEP_T0   = 5'd9;
    localparam logic [4:0] STEP_K0   = 5'd12;
    localparam logic [4:0] STEP_LAST = 5'd23;

    // node table, one write port and one read port each
    logic [95:0]  pos_mem [NODES];
    logic [127:0] rot_mem [NODES];
    logic [95:0]  scl_mem [NODES];
    logic [10:0]  par_mem [NODES];
    logic [95:0]  pos_rd_reg;
    logic [127:0] rot_rd_reg;
    logic [95:0]  scl_rd_reg;
    logic [10:0]  par_rd_reg;
    logic [IDX_W-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [4:0]          step_reg, step_next;
    logic [LIMIT_W-1:0]  hops_reg, hops_next;
    logic [LIMIT_W-1:0]  hop_limit_reg;
    logic [IDX_W-1:0]    e_reg;
    logic [10:0]         link_reg;
    logic                hit_reg;
    logic signed [31:0]  v_reg [3];
    logic signed [31:0]  t_reg [3];
    logic signed [ACC_W-1:0] acc_reg [3];
    qprod_t              qp_reg;

    logic               in_acc;
    logic [2:0]         op;
    logic [IDX_W-1:0]   entry;
    logic signed [31:0] fa, fb, fc, fd;
    logic               link_ok;
    logic [LIMIT_W-1:0] limit;
    logic signed [31:0] mul_a, mul_b;
    rnd_t               rnd;
    logic [4:0]         rstep;
    logic signed [31:0] t_new;
    logic [1:0]         tsel;
    logic [3:0]         kidx;

    assign op    = s_tuser;
    assign entry = s_tdata[9:0];
    assign fa    = s_tdata[41:10];
    assign fb    = s_tdata[73:42];
    assign fc    = s_tdata[105:74];
    assign fd    = s_tdata[137:106];

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // apb: single register, always ready
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {{(32-LIMIT_W){1'b0}}, hop_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hop_limit_reg <= LIMIT_W'(HOP_MAX);
        else if (psel && penable && pwrite && (paddr == 1'b0))
            hop_limit_reg <= pwdata[LIMIT_W-1:0];
    end

    assign limit = (hop_limit_reg > LIMIT_W'(HOP_MAX)) ? LIMIT_W'(HOP_MAX) : hop_limit_reg;

    // parent link usable: not root and no greater than the queried node
    assign link_ok = !link_reg[10] && (link_reg[IDX_W-1:0] <= e_reg);

    // read address: the queried node on acceptance, else the current parent
    always_comb
    begin
        if (state_reg == S_IDLE)
            rd_addr = entry;
        else
            rd_addr = link_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && op == OP_POS)
            pos_mem[entry] <= {fc, fb, fa};
        if (in_acc && op == OP_ROT)
            rot_mem[entry] <= {fd, fc, fb, fa};
        if (in_acc && op == OP_SCALE)
            scl_mem[entry] <= {fc, fb, fa};
        if (in_acc && op == OP_PAR)
        begin
            // out-of-range parents are stored as root
            if (fa[31] || fa > 32'sd1023)
                par_mem[entry] <= 11'h7ff;
            else
                par_mem[entry] <= {1'b0, fa[IDX_W-1:0]};
        end
        pos_rd_reg <= pos_mem[rd_addr];
        rot_rd_reg <= rot_mem[rd_addr];
        scl_rd_reg <= scl_mem[rd_addr];
        par_rd_reg <= par_mem[rd_addr];
    end

    // operand selection for the shared multiplier
    assign kidx = 4'(step_reg - STEP_K0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            5'd0:  begin mul_a = rot_rd_reg[31:0];   mul_b = rot_rd_reg[31:0];    end
            5'd1:  begin mul_a = rot_rd_reg[63:32];  mul_b = rot_rd_reg[63:32];   end
            5'd2:  begin mul_a = rot_rd_reg[95:64];  mul_b = rot_rd_reg[95:64];   end
            5'd3:  begin mul_a = rot_rd_reg[31:0];   mul_b = rot_rd_reg[63:32];   end
            5'd4:  begin mul_a = rot_rd_reg[31:0];   mul_b = rot_rd_reg[95:64];   end
            5'd5:  begin mul_a = rot_rd_reg[63:32];  mul_b = rot_rd_reg[95:64];   end
            5'd6:  begin mul_a = rot_rd_reg[31:0];   mul_b = rot_rd_reg[127:96];  end
            5'd7:  begin mul_a = rot_rd_reg[63:32];  mul_b = rot_rd_reg[127:96];  end
            5'd8:  begin mul_a = rot_rd_reg[95:64];  mul_b = rot_rd_reg[127:96];  end
            5'd9:  begin mul_a = scl_rd_reg[31:0];   mul_b = v_reg[0];            end
            5'd10: begin mul_a = scl_rd_reg[63:32];  mul_b = v_reg[1];            end
            5'd11: begin mul_a = scl_rd_reg[95:64];  mul_b = v_reg[2];            end
            5'd12, 5'd15, 5'd18:
                   begin mul_a = kcoef(kidx, qp_reg); mul_b = t_reg[0];           end
            5'd13, 5'd16, 5'd19:
                   begin mul_a = kcoef(kidx, qp_reg); mul_b = t_reg[1];           end
            5'd14, 5'd17, 5'd20:
                   begin mul_a = kcoef(kidx, qp_reg); mul_b = t_reg[2];           end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    tcwp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .rnd (rnd)
    );

    // rnd belongs to step rstep, issued ahead of the operand and product registers
    assign rstep = step_reg - 5'd2;
    assign tsel  = 2'(rstep - STEP_T0);
    assign t_new = sat32(ACC_W'(rnd));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        hops_next  = hops_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && op == OP_QUERY)
                    state_next = S_START;
            S_START:
            begin
                hops_next  = '0;
                state_next = S_CHECK;
            end
            S_CHECK:
                if (link_ok && hops_reg < limit)
                begin
                    step_next  = '0;
                    state_next = S_HOP;
                end
                else
                    state_next = S_OUT;
            S_HOP:
                if (step_reg == STEP_LAST)
                begin
                    hops_next  = hops_reg + 1'b1;
                    state_next = S_CHECK;
                end
                else
                    step_next = step_reg + 1'b1;
            S_OUT:
                if (m_tready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            hops_reg  <= '0;
            m_tvalid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            hops_reg  <= hops_next;
            m_tvalid  <= (state_next == S_OUT);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc && op == OP_QUERY)
            e_reg <= entry;
        case (state_reg)
            S_START:
            begin
                v_reg[0] <= pos_rd_reg[31:0];
                v_reg[1] <= pos_rd_reg[63:32];
                v_reg[2] <= pos_rd_reg[95:64];
                link_reg <= par_rd_reg;
            end
            S_CHECK:
                hit_reg <= link_ok;
            S_HOP:
            begin
                if (step_reg == 5'd0)
                begin
                    acc_reg[0] <= ACC_W'($signed(pos_rd_reg[31:0]));
                    acc_reg[1] <= ACC_W'($signed(pos_rd_reg[63:32]));
                    acc_reg[2] <= ACC_W'($signed(pos_rd_reg[95:64]));
                end
                if (step_reg >= 5'd2 && step_reg < 5'd11)
                    qp_reg[rstep[3:0]] <= rnd;
                if (step_reg >= 5'd11 && step_reg < 5'd14)
                begin
                    t_reg[tsel]   <= t_new;
                    acc_reg[tsel] <= acc_reg[tsel] + ACC_W'(t_new);
                end
                if (step_reg >= 5'd14 && step_reg < STEP_LAST)
                    acc_reg[(rstep < 5'd15) ? 2'd0 : ((rstep < 5'd18) ? 2'd1 : 2'd2)]
                        <= acc_reg[(rstep < 5'd15) ? 2'd0 : ((rstep < 5'd18) ? 2'd1 : 2'd2)]
                           + ACC_W'(rnd);
                if (step_reg == STEP_LAST)
                begin
                    v_reg[0] <= sat32(acc_reg[0]);
                    v_reg[1] <= sat32(acc_reg[1]);
                    v_reg[2] <= sat32(acc_reg[2]);
                    link_reg <= par_rd_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tdata = {v_reg[2], v_reg[1], v_reg[0]};
    assign m_tuser = hit_reg;

endmodule

// ===== rtl/core/tcwp_mul.sv =====
// shared signed 32x32 multiplier with registered operands and product, and q16 rounding
`timescale 1ns / 1ps
module tcwp_mul (
    input  logic                  clk,
    input  logic signed [31:0]    a,
    input  logic signed [31:0]    b,
    output tcwp_pkg::rnd_t        rnd
);
    import tcwp_pkg::*;

    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [63:0] p_reg;
    logic signed [63:0] biased;

    always_ff @(posedge clk)
    begin
        a_reg <= a;
        b_reg <= b;
        p_reg <= a_reg * b_reg;
    end

    // round half up, floor shift by 16
    assign biased = p_reg + 64'sd32768;
    assign rnd    = biased[63:16];

endmodule

// ===== tb/tb_transform_chain_world_position.sv =====
// self-checking testbench of the transform chain world-position unit
`timescale 1ns / 1ps
module tb_transform_chain_world_position;
    import tcwp_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;
    localparam int POOL_N      = 20;
    localparam int OP_BAD_LO   = 5;   // first unused opcode
    localparam int OP_BAD_HI   = 7;   // last unused opcode

    typedef struct {
        logic [2:0]  op;
        logic [9:0]  entry;
        int          a;
        int          b;
        int          c;
        int          d;
    } node_req_t;

    typedef struct {
        int          wx;
        int          wy;
        int          wz;
        logic        hit;
    } world_pos_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [143:0]  s_tdata = '0;   // entry[9:0], a, b, c, d (32 each), zero fill
    logic [2:0]    s_tuser = '0;   // op
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [95:0]   m_tdata;        // world_x, world_y, world_z
    logic [0:0]    m_tuser;        // limit_hit
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [0:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    transform_chain_world_position uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // mirror of the node table and the hop limit register
    int          tbl_px [NODES];
    int          tbl_py [NODES];
    int          tbl_pz [NODES];
    int          tbl_qx [NODES];
    int          tbl_qy [NODES];
    int          tbl_qz [NODES];
    int          tbl_qw [NODES];
    int          tbl_sx [NODES];
    int          tbl_sy [NODES];
    int          tbl_sz [NODES];
    int          tbl_par [NODES];
    logic [3:0]  tbl_written [NODES];   // pos, rot, scale, parent
    int          hop_lim_reg;

    node_req_t   pending_reqs [$];
    world_pos_t  expected_pos [$];
    int          pool [POOL_N];
    int          fail_cnt = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          gap_cnt = 0;
    int          stall_cnt = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // q16.16 product rounding: add half, floor shift
    function automatic longint rnd16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic bit link_ok(input int link, input int e);
        return link >= 0 && link <= e;
    endfunction

    function automatic int eff_limit();
        return hop_lim_reg > HOP_MAX ? HOP_MAX : hop_lim_reg;
    endfunction

    // one parent hop: v = rot(q, scale*v) + pos
    task automatic apply_hop(input int n, inout longint vx, inout longint vy,
                             inout longint vz);
        longint x, y, z, w;
        longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
        longint k [9];
        longint t0, t1, t2;
        x  = tbl_qx[n];
        y  = tbl_qy[n];
        z  = tbl_qz[n];
        w  = tbl_qw[n];
        xx = rnd16(x * x);
        yy = rnd16(y * y);
        zz = rnd16(z * z);
        xy = rnd16(x * y);
        xz = rnd16(x * z);
        yz = rnd16(y * z);
        xw = rnd16(x * w);
        yw = rnd16(y * w);
        zw = rnd16(z * w);
        k[0] = clamp32(-2 * (yy + zz));
        k[1] = clamp32(2 * (xy - zw));
        k[2] = clamp32(2 * (xz + yw));
        k[3] = clamp32(2 * (xy + zw));
        k[4] = clamp32(-2 * (xx + zz));
        k[5] = clamp32(2 * (yz - xw));
        k[6] = clamp32(2 * (xz - yw));
        k[7] = clamp32(2 * (yz + xw));
        k[8] = clamp32(-2 * (xx + yy));
        t0 = clamp32(rnd16(longint'(tbl_sx[n]) * vx));
        t1 = clamp32(rnd16(longint'(tbl_sy[n]) * vy));
        t2 = clamp32(rnd16(longint'(tbl_sz[n]) * vz));
        vx = clamp32(t0 + tbl_px[n] + rnd16(k[0] * t0) + rnd16(k[1] * t1) + rnd16(k[2] * t2));
        vy = clamp32(t1 + tbl_py[n] + rnd16(k[3] * t0) + rnd16(k[4] * t1) + rnd16(k[5] * t2));
        vz = clamp32(t2 + tbl_pz[n] + rnd16(k[6] * t0) + rnd16(k[7] * t1) + rnd16(k[8] * t2));
    endtask

    // a query is only legal when every table read of its walk hits written data
    function automatic bit walk_defined(input int e);
        int link;
        int hops;
        if (!tbl_written[e][0] || !tbl_written[e][3])
            return 1'b0;
        link = tbl_par[e];
        hops = 0;
        while (link_ok(link, e) && hops < eff_limit())
        begin
            if (tbl_written[link] != 4'b1111)
                return 1'b0;
            link = tbl_par[link];
            hops++;
        end
        return 1'b1;
    endfunction

    task automatic predict_world(input int e);
        longint     vx, vy, vz;
        int         link;
        int         hops;
        world_pos_t r;
        vx   = tbl_px[e];
        vy   = tbl_py[e];
        vz   = tbl_pz[e];
        link = tbl_par[e];
        hops = 0;
        while (link_ok(link, e) && hops < eff_limit())
        begin
            apply_hop(link, vx, vy, vz);
            link = tbl_par[link];
            hops++;
        end
        r.wx  = int'(vx);
        r.wy  = int'(vy);
        r.wz  = int'(vz);
        r.hit = link_ok(link, e);
        expected_pos.push_back(r);
    endtask

    // queue one request and update the mirror; undefined queries are dropped
    task automatic post_request(input int op, input int e, input int a, input int b,
                                input int c, input int d);
        node_req_t rq;
        if (op == OP_QUERY && !walk_defined(e))
            return;
        rq.op    = op[2:0];
        rq.entry = e[9:0];
        rq.a     = a;
        rq.b     = b;
        rq.c     = c;
        rq.d     = d;
        case (op)
            OP_POS:
            begin
                tbl_px[e] = a; tbl_py[e] = b; tbl_pz[e] = c;
                tbl_written[e][0] = 1'b1;
            end
            OP_ROT:
            begin
                tbl_qx[e] = a; tbl_qy[e] = b; tbl_qz[e] = c; tbl_qw[e] = d;
                tbl_written[e][1] = 1'b1;
            end
            OP_SCALE:
            begin
                tbl_sx[e] = a; tbl_sy[e] = b; tbl_sz[e] = c;
                tbl_written[e][2] = 1'b1;
            end
            OP_PAR:
            begin
                tbl_par[e] = (a < 0 || a >= NODES) ? -1 : a;
                tbl_written[e][3] = 1'b1;
            end
            OP_QUERY: predict_world(e);
            default: ;
        endcase
        pending_reqs.push_back(rq);
    endtask

    // mostly moderate q16.16 values, sometimes anything at all
    function automatic int rand_val();
        if ($urandom_range(0, 9) < 3)
            return $urandom;
        return int'($urandom_range(0, 262144)) - 131072;
    endfunction

    function automatic int rand_pool_le(input int e);
        int p;
        do
            p = pool[$urandom_range(0, POOL_N - 1)];
        while (p > e);
        return p;
    endfunction

    function automatic int rand_parent(input int e);
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return rand_pool_le(e);
        if (r < 15)
            return -int'($urandom_range(1, 1000));
        if (r < 17)
            return int'($urandom_range(NODES, 65535));
        if (r < 18)
            return e;
        return $urandom;
    endfunction

    task automatic random_request();
        int r;
        int e;
        int g;
        r = $urandom_range(0, 99);
        e = pool[$urandom_range(0, POOL_N - 1)];
        if (r < 42)
            post_request(OP_QUERY, e, $urandom, $urandom, $urandom, $urandom);
        else if (r < 90 || r < 96)
        begin
            // pool writes, with a slice going to any entry of the table
            if (r >= 90)
                e = $urandom_range(0, NODES - 1);
            g = $urandom_range(OP_POS, OP_PAR);
            if (g == OP_PAR)
                post_request(g, e, rand_parent(e), $urandom, $urandom, $urandom);
            else
                post_request(g, e, rand_val(), rand_val(), rand_val(), rand_val());
        end
        else
            post_request($urandom_range(OP_BAD_LO, OP_BAD_HI), $urandom_range(0, NODES - 1),
                         $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_pos.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_hop_limit(input int value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hop_lim_reg = value & 32'h1ff;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_cnt++;
    endtask

    // request driver with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_cnt  <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_cnt > 0 && !quiet)
            begin
                gap_cnt  <= gap_cnt - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                node_req_t rq;
                rq = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, rq.d, rq.c, rq.b, rq.a, rq.entry};
                s_tuser  <= rq.op;
                if (!quiet && $urandom_range(0, 5) == 0)
                    gap_cnt <= $urandom_range(1, 19);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pos.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], 0);
                else
                begin
                    world_pos_t w;
                    w = expected_pos.pop_front();
                    if (m_tdata[31:0] !== w.wx)
                        report_mismatch("world_x", m_tdata[31:0], w.wx);
                    if (m_tdata[63:32] !== w.wy)
                        report_mismatch("world_y", m_tdata[63:32], w.wy);
                    if (m_tdata[95:64] !== w.wz)
                        report_mismatch("world_z", m_tdata[95:64], w.wz);
                    if (m_tuser[0] !== w.hit)
                        report_mismatch("limit_hit", m_tuser[0], w.hit);
                end
            end
            if (quiet)
                m_tready <= 1'b1;
            else if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_cnt <= $urandom_range(1, 19);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int limits [8];
        int p;
        int i;
        int k;
        bit dup;
        limits = '{1, 0, 3, 511, 8, 2, 256, 4};
        hop_lim_reg = HOP_MAX;
        for (i = 0; i < NODES; i++)
            tbl_written[i] = 4'b0000;

        // node pool: both ends of the index range, entries 512 and 1, plus random entries
        pool[0] = 0;
        pool[1] = NODES - 1;
        pool[2] = 512;
        pool[3] = 1;
        for (i = 4; i < POOL_N; i++)
        begin
            do
            begin
                p   = $urandom_range(0, NODES - 1);
                dup = 1'b0;
                for (k = 0; k < i; k++)
                    if (pool[k] == p)
                        dup = 1'b1;
            end
            while (dup);
            pool[i] = p;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of hop_limit is used for the first phase
        for (i = 0; i < POOL_N; i++)
        begin
            post_request(OP_POS, pool[i], rand_val(), rand_val(), rand_val(), $urandom);
            post_request(OP_ROT, pool[i], rand_val(), rand_val(), rand_val(), rand_val());
            post_request(OP_SCALE, pool[i], rand_val(), rand_val(), rand_val(), $urandom);
            post_request(OP_PAR, pool[i], rand_parent(pool[i]), $urandom, $urandom, $urandom);
        end

        // directed: extreme fields, every defined op and both ends of the unused range, out-of-range parents, self loop
        post_request(OP_POS, 0, 32'sh7fffffff, 32'sh80000000, 0, 0);
        post_request(OP_ROT, 0, 0, 0, 0, 32'sh00010000);
        post_request(OP_SCALE, 0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0);
        post_request(OP_PAR, 0, -1, 0, 0, 0);
        post_request(OP_QUERY, 0, 0, 0, 0, 0);
        post_request(OP_ROT, 1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        post_request(OP_SCALE, 1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        post_request(OP_POS, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0);
        post_request(OP_PAR, 1, 0, 0, 0, 0);
        post_request(OP_PAR, NODES - 1, 1, 0, 0, 0);
        post_request(OP_QUERY, NODES - 1, -1, -1, -1, -1);
        post_request(OP_PAR, NODES - 1, NODES, 0, 0, 0);
        post_request(OP_QUERY, NODES - 1, 0, 0, 0, 0);
        post_request(OP_PAR, NODES - 1, 32'sh7fffffff, 0, 0, 0);
        post_request(OP_QUERY, NODES - 1, 0, 0, 0, 0);
        post_request(OP_PAR, 1, 1, 0, 0, 0);
        post_request(OP_QUERY, 1, 0, 0, 0, 0);
        post_request(OP_PAR, NODES - 1, NODES - 1, 0, 0, 0);
        post_request(OP_QUERY, NODES - 1, 0, 0, 0, 0);
        post_request(OP_BAD_HI, NODES - 1, -1, -1, -1, -1);
        post_request(OP_BAD_LO, 0, 0, 0, 0, 0);
        post_request(OP_PAR, 1, 0, 0, 0, 0);
        post_request(OP_PAR, NODES - 1, 0, 0, 0, 0);
        post_request(OP_QUERY, 1, 0, 0, 0, 0);
        for (i = 0; i < 40; i++)
            random_request();
        wait_idle();

        // random phases under a range of hop limits, the last one without idling
        for (p = 0; p < 8; p++)
        begin
            write_hop_limit(limits[p]);
            if (p == 7)
                quiet = 1'b1;
            for (i = 0; i < 75; i++)
                random_request();
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
